// ===== rtl/etfp_pkg.sv =====
// shared types, constants and helpers for the escape-time fractal pixel unit
// no dependencies
package etfp_pkg;

  localparam int FRAC_BITS_DEF = 56;
  localparam int NUM_CELLS     = 4;
  localparam int HALF_W        = 32;
  localparam logic [15:0] ITER_LIMIT_RST = 16'd256;

  typedef enum logic [2:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_STEP_X   = 3'd2,
    REG_STEP_Y   = 3'd3,
    REG_JULIA_EN = 3'd4,
    REG_JULIA_RE = 3'd5,
    REG_JULIA_IM = 3'd6,
    REG_ITER_LIM = 3'd7
  } reg_idx_t;

  // word travelling down the multiplier chain
  typedef struct packed {
    logic         vld;
    logic [1:0]   tag;
    logic         neg;
    logic [63:0]  opa;
    logic [63:0]  opb;
    logic [127:0] acc;
  } mul_word_t;

  // clamp a signed 128-bit value to the signed 64-bit range
  function automatic logic [63:0] sat128(input logic [127:0] v);
    logic [63:0] res;
    if (v[127:63] == {65{1'b0}} || v[127:63] == {65{1'b1}}) begin
      res = v[63:0];
    end else if (v[127]) begin
      res = {1'b1, 63'd0};
    end else begin
      res = {1'b0, {63{1'b1}}};
    end
    return res;
  endfunction

  function automatic logic [127:0] sext64(input logic [63:0] v);
    return {{64{v[63]}}, v};
  endfunction

endpackage

// ===== rtl/etfp_cell.sv =====
// one cell of the multiplier chain: adds one 32x32 partial product
// depends on etfp_pkg
module etfp_cell import etfp_pkg::*; #(
  parameter int CELL_IDX = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  mul_word_t word_i,
  output mul_word_t word_o
);

  localparam int SEL_A = CELL_IDX / 2;
  localparam int SEL_B = CELL_IDX % 2;
  localparam int SHIFT = HALF_W * (SEL_A + SEL_B);

  logic [HALF_W-1:0]   half_a;
  logic [HALF_W-1:0]   half_b;
  logic [2*HALF_W-1:0] pp;
  mul_word_t           word_r;
  mul_word_t           word_nxt;

  assign half_a = word_i.opa[SEL_A*HALF_W +: HALF_W];
  assign half_b = word_i.opb[SEL_B*HALF_W +: HALF_W];
  assign pp     = half_a * half_b;

  always_comb begin
    word_nxt     = word_i;
    word_nxt.acc = word_i.acc + ({64'd0, pp} << SHIFT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r.vld <= 1'b0;
    end else begin
      word_r.vld <= word_nxt.vld;
    end
    word_r.tag <= word_nxt.tag;
    word_r.neg <= word_nxt.neg;
    word_r.opa <= word_nxt.opa;
    word_r.opb <= word_nxt.opb;
    word_r.acc <= word_nxt.acc;
  end

  assign word_o = word_r;

endmodule

// ===== rtl/escape_time_fractal_pixel_unit.sv =====
// escape-time fractal pixel unit: sequencer, result stage and multiplier chain
// depends on etfp_pkg and etfp_cell
//
// usage:
//   cfg channel writes the eight registers (index 0..7); the user writes them
//   only while the unit is idle (unenforced); cfg_ready is always high.
//   in channel takes one pixel word (column, row); the unit works on one pixel
//   at a time and in_ready is high only while it is idle.
//   out channel returns the escape count for that pixel in a held register, so
//   the next pixel is taken while a finished count still waits for out_ready.
// datapath:
//   every 64x64 product goes through a chain of four partial-product cells plus
//   one result stage; the pixel point takes two products, and each iteration
//   round is a bound check, three products issued back to back, then the wait
//   for the chain and the result stage.
// reset:
//   synchronous, active low; configuration registers go to zero, the iteration
//   limit to 256, no word is in flight and out_valid is low.
// a stalled receiver only holds the finished count; the unit then waits in its
// finish state until the output register is free.
module escape_time_fractal_pixel_unit import etfp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] in_column,
  input  logic [11:0] in_row,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_escape_count
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_PT    = 8'b0000_0010,
    S_PTW   = 8'b0000_0100,
    S_PTSUM = 8'b0000_1000,
    S_CHK   = 8'b0001_0000,
    S_RND   = 8'b0010_0000,
    S_RNDW  = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

  localparam logic [63:0] BOUND = 64'd16 << FRAC_BITS;

  // configuration
  logic [63:0] org_x_r, org_y_r, jre_r, jim_r;
  logic [62:0] step_x_r, step_y_r;
  logic        jen_r;
  logic [15:0] lim_r;

  // pixel state
  state_t      state_r, state_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [1:0]  rcnt_r, rcnt_nxt;
  logic [11:0] col_r, row_r;
  logic [63:0] a_r, b_r, cx_r, cy_r;
  logic [15:0] cnt_r;
  logic [63:0] fx_r [3];
  logic [75:0] raw_r [2];
  logic        out_valid_r;
  logic [15:0] out_cnt_r;

  mul_word_t   chain [NUM_CELLS+1];
  mul_word_t   issue;

  logic [63:0]  mag_a, mag_b;
  logic [127:0] signed_prod, shifted;
  logic [63:0]  fx_val;
  logic [127:0] pt_x, pt_y, next_a, next_b;
  logic [63:0]  px, py, sq_sum;
  logic         esc;
  logic         out_free;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_escape_count = out_cnt_r;
  assign out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r  <= '0;
      org_y_r  <= '0;
      step_x_r <= '0;
      step_y_r <= '0;
      jen_r    <= 1'b0;
      jre_r    <= '0;
      jim_r    <= '0;
      lim_r    <= ITER_LIMIT_RST;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_ORIGIN_X: org_x_r  <= cfg_data;
        REG_ORIGIN_Y: org_y_r  <= cfg_data;
        REG_STEP_X:   step_x_r <= cfg_data[62:0];
        REG_STEP_Y:   step_y_r <= cfg_data[62:0];
        REG_JULIA_EN: jen_r    <= cfg_data[0];
        REG_JULIA_RE: jre_r    <= cfg_data;
        REG_JULIA_IM: jim_r    <= cfg_data;
        REG_ITER_LIM: lim_r    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // operand magnitudes for the round products
  assign mag_a = a_r[63] ? (64'd0 - a_r) : a_r;
  assign mag_b = b_r[63] ? (64'd0 - b_r) : b_r;

  always_comb begin
    issue     = '0;
    issue.tag = idx_r;
    if (state_r == S_PT) begin
      issue.vld = 1'b1;
      if (idx_r == 2'd0) begin
        issue.opa = {52'd0, col_r};
        issue.opb = {1'b0, step_x_r};
      end else begin
        issue.opa = {52'd0, row_r};
        issue.opb = {1'b0, step_y_r};
      end
    end else if (state_r == S_RND) begin
      issue.vld = 1'b1;
      case (idx_r)
        2'd0: begin
          issue.opa = mag_a;
          issue.opb = mag_a;
        end
        2'd1: begin
          issue.opa = mag_b;
          issue.opb = mag_b;
        end
        default: begin
          issue.opa = mag_a;
          issue.opb = mag_b;
          issue.neg = a_r[63] ^ b_r[63];
        end
      endcase
    end
  end

  assign chain[0] = issue;

  for (genvar gi = 0; gi < NUM_CELLS; gi++) begin : g_cell
    etfp_cell #(.CELL_IDX(gi)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .word_i (chain[gi]),
      .word_o (chain[gi+1])
    );
  end

  // result stage: sign, scale, clamp
  assign signed_prod = chain[NUM_CELLS].neg ? (128'd0 - chain[NUM_CELLS].acc)
                                            : chain[NUM_CELLS].acc;
  assign shifted     = $signed(signed_prod) >>> FRAC_BITS;
  assign fx_val      = sat128(shifted);

  always_ff @(posedge clk) begin
    if (chain[NUM_CELLS].vld) begin
      fx_r[chain[NUM_CELLS].tag] <= fx_val;
      if (chain[NUM_CELLS].tag != 2'd2) begin
        raw_r[chain[NUM_CELLS].tag[0]] <= chain[NUM_CELLS].acc[75:0];
      end
    end
  end

  assign pt_x   = sext64(org_x_r) + {52'd0, raw_r[0]};
  assign pt_y   = sext64(org_y_r) + {52'd0, raw_r[1]};
  assign px     = sat128(pt_x);
  assign py     = sat128(pt_y);
  assign sq_sum = fx_r[0] + fx_r[1];
  assign esc    = sq_sum > BOUND;
  assign next_a = sext64(fx_r[0]) - sext64(fx_r[1]) + sext64(cx_r);
  assign next_b = sext64(fx_r[2]) + sext64(fx_r[2]) + sext64(cy_r);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    rcnt_nxt  = rcnt_r + {1'b0, chain[NUM_CELLS].vld};
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_PT;
        end
      end
      S_PT: begin
        idx_nxt = idx_r + 2'd1;
        if (idx_r == 2'd1) begin
          idx_nxt   = 2'd0;
          state_nxt = S_PTW;
        end
      end
      S_PTW: begin
        if (rcnt_r == 2'd2) begin
          rcnt_nxt  = 2'd0;
          state_nxt = S_PTSUM;
        end
      end
      S_PTSUM: state_nxt = S_CHK;
      S_CHK: begin
        state_nxt = (cnt_r == lim_r) ? S_FIN : S_RND;
      end
      S_RND: begin
        idx_nxt = idx_r + 2'd1;
        if (idx_r == 2'd2) begin
          idx_nxt   = 2'd0;
          state_nxt = S_RNDW;
        end
      end
      S_RNDW: begin
        if (rcnt_r == 2'd3) begin
          rcnt_nxt  = 2'd0;
          state_nxt = esc ? S_FIN : S_CHK;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= 2'd0;
      rcnt_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      rcnt_r  <= rcnt_nxt;
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      col_r <= in_column;
      row_r <= in_row;
      cnt_r <= 16'd0;
    end
    if (state_r == S_PTSUM) begin
      a_r  <= px;
      b_r  <= py;
      cx_r <= jen_r ? jre_r : px;
      cy_r <= jen_r ? jim_r : py;
    end
    if (state_r == S_RNDW && rcnt_r == 2'd3 && !esc) begin
      a_r   <= sat128(next_a);
      b_r   <= sat128(next_b);
      cnt_r <= cnt_r + 16'd1;
    end
    if (state_r == S_FIN && out_free) begin
      out_cnt_r <= (cnt_r == 16'd0) ? lim_r : cnt_r;
    end
  end

`ifndef ASSERT_OFF
  a_chain_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    chain[NUM_CELLS].vld |-> (state_r == S_PTW || state_r == S_RNDW))
    else $error("product left the chain outside a wait state");
  a_rcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PTW) |-> (rcnt_r != 2'd3))
    else $error("too many point products returned");
  a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && !out_valid_r) |=> out_valid_r)
    else $error("finished count not loaded into a free output register");
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_cnt_r != 16'd0 || lim_r == 16'd0))
    else $error("zero count reported with nonzero limit");
`endif

endmodule
